// File: sv/ssll_pkg.sv
// Package for the sorted linked list core: store geometry, command codes and beat types.
// Has no dependencies; every other file in the project but ssll_ram imports it.
package ssll_pkg;

    // Number of storage slots in the key and link stores.
    localparam int DEPTH = 64;

    // A slot index, and a link that can also hold the "none" code.
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LINK_W = $clog2(DEPTH + 1);

    // Fixed field widths of the beats.
    localparam int KIND_W    = 3;
    localparam int KEY_W     = 32;
    localparam int SLOT_W    = 6;
    localparam int ENTRIES_W = 7;

    // The link code for "no slot"; it also serves as the walk step limit.
    localparam logic [LINK_W-1:0] NONE_LINK  = LINK_W'(DEPTH);
    localparam logic [LINK_W-1:0] STEP_LIMIT = LINK_W'(DEPTH);

    // Command codes.
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    // Command beat.
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
    } cmd_t;

    // Result beat.
    typedef struct packed {
        logic                 ok;
        logic [SLOT_W-1:0]    slot;
        logic [ENTRIES_W-1:0] entries;
    } res_t;

    // Access request to the link store.
    typedef struct packed {
        logic              clr;
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } link_req_t;

endpackage

// File: sv/ssll_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone: no package or submodules.
module ssll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read in the same cycle as a write sees old data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/ssll_link_mem.sv
// Link store of the sorted list: a RAM of next-slot links plus one valid flag per slot.
// Depends on ssll_pkg and ssll_ram.
module ssll_link_mem (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ssll_pkg::link_req_t               req,
    output logic [ssll_pkg::LINK_W-1:0]       rdata
);
    import ssll_pkg::*;

    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic              rd_vld_reg;
    logic [LINK_W-1:0] rd_def_reg;
    logic [LINK_W-1:0] rd_def_next;
    logic [LINK_W-1:0] ram_q;

    ssll_ram #(
        .WIDTH (LINK_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .raddr (req.raddr),
        .rdata (ram_q)
    );

    // A slot never written since reset or clear links to the slot after it, the last to none.
    always_comb begin
        valid_next = valid_reg;
        if (req.clr) begin
            valid_next = '0;
        end else if (req.we) begin
            valid_next[req.waddr] = 1'b1;
        end
        if (req.raddr == IDX_W'(DEPTH - 1)) begin
            rd_def_next = NONE_LINK;
        end else begin
            rd_def_next = LINK_W'(req.raddr) + LINK_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
        rd_vld_reg <= valid_reg[req.raddr];
        rd_def_reg <= rd_def_next;
    end

    assign rdata = rd_vld_reg ? ram_q : rd_def_reg;

endmodule

// File: sv/sorted_static_linked_list_core.sv
// Sorted linked list core: the top level with the command sequencer and the key store.
// Depends on ssll_pkg, ssll_ram and ssll_link_mem.
//
// A set of up to DEPTH signed 32-bit keys, held as a singly linked list in ascending order
// with unused slots on a free chain. Each command beat gives exactly one result beat. The
// block takes one command at a time: search, insert and delete walk the list one link per
// cycle through the single read port of the key and link stores. An insert into a full
// store skips the walk. The free chain comes out of reset ready to use, with no clearing
// pass, and a clear command rebuilds it by clearing the valid flags of the link store. A
// finished result waits in an output register, so the next command may be taken while it
// is still unclaimed.
module sorted_static_linked_list_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ssll_pkg::cmd_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ssll_pkg::res_t m_data
);
    import ssll_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_INS_RD,
        ST_INS_WR,
        ST_LINK_PREV,
        ST_DEL_WR,
        ST_DONE
    } state_t;

    // Control state.
    state_t            state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    logic [LINK_W-1:0] list_head_reg, list_head_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] count_reg, count_next;

    // Per-command working registers.
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic signed [KEY_W-1:0] k_reg, k_next;
    logic [LINK_W-1:0]       cur_reg, cur_next;
    logic [LINK_W-1:0]       prev_reg, prev_next;
    logic [LINK_W-1:0]       steps_reg, steps_next;
    logic [LINK_W-1:0]       patch_reg, patch_next;
    logic                    ok_reg, ok_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    res_t                    m_data_reg, m_data_next;

    // Store access.
    link_req_t         link_req;
    logic [LINK_W-1:0] link_rd;
    logic [IDX_W-1:0]  rd_addr;
    logic              key_we;
    logic [KEY_W-1:0]  key_rd;

    ssll_link_mem u_link (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (link_req),
        .rdata   (link_rd)
    );

    ssll_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_keys (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (free_head_reg[IDX_W-1:0]),
        .wdata (k_reg),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    // Sequencer: one walk step per cycle, then relinking through the single write port.
    always_comb begin
        logic found;
        found          = 1'b0;
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        patch_next     = patch_reg;
        ok_next        = ok_reg;
        slot_next      = slot_reg;
        rd_addr        = cur_reg[IDX_W-1:0];
        link_req       = '0;
        key_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_data.kind;
                    k_next     = s_data.key;
                    cur_next   = list_head_reg;
                    prev_next  = NONE_LINK;
                    steps_next = '0;
                    ok_next    = 1'b0;
                    slot_next  = '0;
                    rd_addr    = list_head_reg[IDX_W-1:0];
                    case (s_data.kind) inside
                        KIND_SEARCH, KIND_DELETE: begin
                            state_next = ST_WALK;
                        end
                        KIND_INSERT: begin
                            state_next = (free_head_reg == NONE_LINK) ? ST_DONE : ST_WALK;
                        end
                        KIND_COUNT: begin
                            ok_next    = 1'b1;
                            state_next = ST_DONE;
                        end
                        KIND_CLEAR: begin
                            link_req.clr   = 1'b1;
                            list_head_next = NONE_LINK;
                            free_head_next = '0;
                            count_next     = '0;
                            ok_next        = 1'b1;
                            state_next     = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (cur_reg != NONE_LINK && steps_reg != STEP_LIMIT
                        && $signed(key_rd) < k_reg) begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    steps_next = steps_reg + LINK_W'(1);
                    rd_addr    = link_rd[IDX_W-1:0];
                end else begin
                    found = (cur_reg != NONE_LINK) && (steps_reg != STEP_LIMIT)
                            && ($signed(key_rd) == k_reg);
                    patch_next = link_rd;
                    case (kind_reg)
                        KIND_SEARCH: begin
                            ok_next    = found;
                            slot_next  = found ? SLOT_W'(cur_reg) : '0;
                            state_next = ST_DONE;
                        end
                        KIND_INSERT: begin
                            state_next = found ? ST_DONE : ST_INS_RD;
                        end
                        default: begin
                            state_next = found ? ST_DEL_WR : ST_DONE;
                        end
                    endcase
                end
            end
            ST_INS_RD: begin
                // Fetch the successor of the free head.
                rd_addr    = free_head_reg[IDX_W-1:0];
                state_next = ST_INS_WR;
            end
            ST_INS_WR: begin
                // The new slot takes the key and links to the first key not below it.
                key_we         = 1'b1;
                link_req.we    = 1'b1;
                link_req.waddr = free_head_reg[IDX_W-1:0];
                link_req.wdata = cur_reg;
                free_head_next = link_rd;
                count_next     = count_reg + LINK_W'(1);
                ok_next        = 1'b1;
                slot_next      = SLOT_W'(free_head_reg);
                if (prev_reg == NONE_LINK) begin
                    list_head_next = free_head_reg;
                    state_next     = ST_DONE;
                end else begin
                    patch_next = free_head_reg;
                    state_next = ST_LINK_PREV;
                end
            end
            ST_DEL_WR: begin
                // Push the removed slot onto the free chain.
                link_req.we    = 1'b1;
                link_req.waddr = cur_reg[IDX_W-1:0];
                link_req.wdata = free_head_reg;
                free_head_next = cur_reg;
                if (count_reg != '0) begin
                    count_next = count_reg - LINK_W'(1);
                end
                ok_next = 1'b1;
                if (prev_reg == NONE_LINK) begin
                    list_head_next = patch_reg;
                    state_next     = ST_DONE;
                end else begin
                    state_next = ST_LINK_PREV;
                end
            end
            ST_LINK_PREV: begin
                link_req.we    = 1'b1;
                link_req.waddr = prev_reg[IDX_W-1:0];
                link_req.wdata = patch_reg;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_data_next.ok      = ok_reg;
                    m_data_next.slot    = slot_reg;
                    m_data_next.entries = ENTRIES_W'(count_reg);
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        link_req.raddr = rd_addr;
    end

    // State, registered outputs and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            list_head_reg <= NONE_LINK;
            free_head_reg <= '0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
        end
        m_data_reg <= m_data_next;
        kind_reg   <= kind_next;
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        steps_reg  <= steps_next;
        patch_reg  <= patch_next;
        ok_reg     <= ok_next;
        slot_reg   <= slot_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: sv/ssll_checker.sv
// Port-level checks for the sorted linked list core, bound to its top level.
// Depends on ssll_pkg and sorted_static_linked_list_core.
module ssll_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input ssll_pkg::res_t m_data
);
    import ssll_pkg::*;

    // A stalled result beat holds.
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Taking a command always makes the block busy and drops ready.
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command accepted on consecutive cycles");

    // A failed command never reports a slot.
    a_fail_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.ok |-> m_data.slot == '0)
        else $error("failed command reported a slot");

    // The list never holds more keys than slots.
    a_entries_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.entries <= ENTRIES_W'(DEPTH))
        else $error("entry count exceeds the store size");

endmodule

bind sorted_static_linked_list_core ssll_checker u_ssll_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the sorted linked list core: a directed table, then random traffic.
// Depends on ssll_pkg and sorted_static_linked_list_core; holds its own shadow of the list state.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssll_pkg::*;

    // Command codes that the block does not use.
    localparam logic [KIND_W-1:0] KIND_RSVD_5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MIN     = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_NEG_ONE = -32'sd1;

    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 600;
    localparam int PHASE_ITEMS    = 530;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        cmd_t cmd;
        bit   typed;
        res_t res;
    } dir_row_t;

    typedef struct {
        bit   typed;
        res_t res;
    } pinned_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cmd_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_data;

    // Shadow copy of the list state.
    logic signed [KEY_W-1:0] shadow_key [DEPTH];
    logic [LINK_W-1:0]       shadow_link [DEPTH];
    logic [LINK_W-1:0]       shadow_head;
    logic [LINK_W-1:0]       shadow_free;
    logic [ENTRIES_W-1:0]    shadow_count;

    res_t                    result_q [$];
    pinned_t                 pinned_q [$];
    dir_row_t                dir_tab [$];
    logic signed [KEY_W-1:0] key_pool [$];

    int fail_cnt    = 0;
    int idle_cycles = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    int items_sent  = 0;

    always #5 aclk = ~aclk;

    sorted_static_linked_list_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Back to the empty list with every slot on the free chain in order.
    function void shadow_clear();
        int i;
        for (i = 0; i < DEPTH; i++) begin
            shadow_link[i] = LINK_W'(i + 1);
            shadow_key[i]  = '0;
        end
        shadow_link[DEPTH-1] = NONE_LINK;
        shadow_head  = NONE_LINK;
        shadow_free  = '0;
        shadow_count = '0;
    endfunction

    // Walk to the first slot whose key is not below k; prev receives its predecessor.
    function automatic logic [LINK_W-1:0] shadow_walk(input logic signed [KEY_W-1:0] k,
                                                      output logic [LINK_W-1:0] prev);
        logic [LINK_W-1:0] cur;
        int steps;
        cur   = shadow_head;
        prev  = NONE_LINK;
        steps = 0;
        while (cur < NONE_LINK && steps < DEPTH && shadow_key[cur[IDX_W-1:0]] < k) begin
            prev = cur;
            cur  = shadow_link[cur[IDX_W-1:0]];
            steps++;
        end
        if (steps >= DEPTH) cur = NONE_LINK;
        return cur;
    endfunction

    // Apply one command to the shadow state and return the result beat it should give.
    function automatic res_t apply_cmd(input cmd_t c);
        res_t r;
        logic [LINK_W-1:0] prev, cur, fresh;
        r = '0;
        case (c.kind)
            KIND_SEARCH: begin
                cur = shadow_walk(c.key, prev);
                if (cur < NONE_LINK && shadow_key[cur[IDX_W-1:0]] == c.key) begin
                    r.ok   = 1'b1;
                    r.slot = cur[SLOT_W-1:0];
                end
            end
            KIND_INSERT: begin
                if (shadow_free < NONE_LINK) begin
                    cur = shadow_walk(c.key, prev);
                    if (!(cur < NONE_LINK && shadow_key[cur[IDX_W-1:0]] == c.key)) begin
                        fresh = shadow_free;
                        shadow_free = shadow_link[fresh[IDX_W-1:0]];
                        shadow_key[fresh[IDX_W-1:0]] = c.key;
                        if (prev >= NONE_LINK) begin
                            shadow_link[fresh[IDX_W-1:0]] = shadow_head;
                            shadow_head = fresh;
                        end else begin
                            shadow_link[fresh[IDX_W-1:0]] = shadow_link[prev[IDX_W-1:0]];
                            shadow_link[prev[IDX_W-1:0]]  = fresh;
                        end
                        shadow_count++;
                        r.ok   = 1'b1;
                        r.slot = fresh[SLOT_W-1:0];
                    end
                end
            end
            KIND_DELETE: begin
                cur = shadow_walk(c.key, prev);
                if (cur < NONE_LINK && shadow_key[cur[IDX_W-1:0]] == c.key) begin
                    // Removing the first element moves the head on to its successor.
                    if (prev >= NONE_LINK) begin
                        shadow_head = shadow_link[cur[IDX_W-1:0]];
                    end else begin
                        shadow_link[prev[IDX_W-1:0]] = shadow_link[cur[IDX_W-1:0]];
                    end
                    shadow_link[cur[IDX_W-1:0]] = shadow_free;
                    shadow_free = cur;
                    if (shadow_count > 0) shadow_count--;
                    r.ok = 1'b1;
                end
            end
            KIND_COUNT: begin
                r.ok = 1'b1;
            end
            KIND_CLEAR: begin
                shadow_clear();
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        r.entries = shadow_count;
        return r;
    endfunction

    function automatic cmd_t make_cmd(input logic [KIND_W-1:0] kind,
                                      input logic signed [KEY_W-1:0] key);
        cmd_t c;
        c.kind = kind;
        c.key  = key;
        return c;
    endfunction

    // Keys: ones seen before, a narrow band round zero, the extremes, or anything.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 35 && key_pool.size() > 0) begin
            return key_pool[$urandom_range(key_pool.size() - 1)];
        end else if (sel < 60) begin
            v = int'($urandom_range(40)) - 20;
            return v;
        end else if (sel < 75) begin
            case ($urandom_range(5))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return KEY_NEG_ONE;
                3: return '0;
                4: return KEY_MIN + 1;
                default: return KEY_MAX - 1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [KIND_W-1:0] pick_rsvd();
        case ($urandom_range(2))
            0: return KIND_RSVD_5;
            1: return KIND_RSVD_6;
            default: return KIND_RSVD_7;
        endcase
    endfunction

    task automatic add_row(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key,
                           input bit typed, input logic ok, input int slot, input int entries);
        dir_row_t row;
        row.cmd         = make_cmd(kind, key);
        row.typed       = typed;
        row.res.ok      = ok;
        row.res.slot    = SLOT_W'(slot);
        row.res.entries = ENTRIES_W'(entries);
        dir_tab.push_back(row);
    endtask

    // Offer one command beat after a random gap, and hold it until it is taken.
    task automatic send_cmd(input cmd_t c, input bit typed, input res_t res);
        pinned_t p;
        p.typed = typed;
        p.res   = res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        pinned_q.push_back(p);
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key);
        if (kind == KIND_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > DEPTH) void'(key_pool.pop_front());
        end
        if (kind <= KIND_CLEAR) items_sent++;
        send_cmd(make_cmd(kind, key), 1'b0, '0);
    endtask

    // Lower valid and wait until every expected result beat has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (result_q.size() != 0 || pinned_q.size() != 0);
    endtask

    // Random traffic: mixed bursts, fills past capacity, drains and a little noise.
    task automatic run_phase(input int tx_pct, input int rx_pct, input int items);
        int target;
        int sel;
        int len;
        int r;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = items_sent + items;
        while (items_sent < target) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
                repeat (DEPTH + 4) send_op(KIND_INSERT, $urandom);
            end else if (sel < 25) begin
                len = $urandom_range(20, 50);
                repeat (len) send_op(KIND_DELETE, pick_key());
            end else if (sel < 30) begin
                len = $urandom_range(3, 8);
                repeat (len) begin
                    r = $urandom_range(9);
                    if (r < 5) send_op(pick_rsvd(), $urandom);
                    else if (r < 9) send_op(KIND_COUNT, $urandom);
                    else send_op(KIND_CLEAR, $urandom);
                end
            end else begin
                len = $urandom_range(10, 40);
                repeat (len) begin
                    r = $urandom_range(99);
                    if (r < 30) send_op(KIND_SEARCH, pick_key());
                    else if (r < 68) send_op(KIND_INSERT, pick_key());
                    else if (r < 90) send_op(KIND_DELETE, pick_key());
                    else if (r < 94) send_op(KIND_COUNT, pick_key());
                    else if (r < 95) send_op(KIND_CLEAR, pick_key());
                    else send_op(pick_rsvd(), pick_key());
                end
            end
        end
    endtask

    // Check each result beat against the oldest expectation, then predict each command beat.
    always @(posedge aclk) begin : scoreboard
        pinned_t p;
        res_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("unexpected result beat: ok=%0d slot=%0d entries=%0d",
                                 m_data.ok, m_data.slot, m_data.entries);
                end else begin
                    want = result_q.pop_front();
                    if (m_data.ok !== want.ok || m_data.slot !== want.slot ||
                        m_data.entries !== want.entries) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display("mismatch: expected ok=%0d slot=%0d entries=%0d, %s%0d %s%0d %s%0d",
                                     want.ok, want.slot, want.entries,
                                     "got ok=", m_data.ok, "slot=", m_data.slot,
                                     "entries=", m_data.entries);
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = apply_cmd(s_data);
                p = pinned_q.pop_front();
                if (p.typed) want = p.res;
                result_q.push_back(want);
            end
        end
    end

    // Result side: random back-pressure, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        shadow_clear();

        // Directed table: empty list, extremes, duplicates, unused codes, head removal, clear.
        add_row(KIND_COUNT,  32'sd0,      1, 1'b1, 0, 0);
        add_row(KIND_SEARCH, 32'sd0,      1, 1'b0, 0, 0);
        add_row(KIND_DELETE, 32'sd5,      1, 1'b0, 0, 0);
        add_row(KIND_INSERT, KEY_MIN,     1, 1'b1, 0, 1);
        add_row(KIND_INSERT, KEY_MAX,     1, 1'b1, 1, 2);
        add_row(KIND_INSERT, KEY_MAX,     1, 1'b0, 0, 2);
        add_row(KIND_INSERT, KEY_NEG_ONE, 1, 1'b1, 2, 3);
        add_row(KIND_INSERT, 32'sd0,      1, 1'b1, 3, 4);
        add_row(KIND_SEARCH, KEY_MIN,     0, 1'b0, 0, 0);
        add_row(KIND_SEARCH, KEY_MAX,     0, 1'b0, 0, 0);
        add_row(KIND_SEARCH, 32'sd1,      0, 1'b0, 0, 0);
        add_row(KIND_SEARCH, KEY_NEG_ONE, 0, 1'b0, 0, 0);
        add_row(KIND_RSVD_5, KEY_NEG_ONE, 1, 1'b0, 0, 4);
        add_row(KIND_RSVD_6, KEY_MAX,     1, 1'b0, 0, 4);
        add_row(KIND_RSVD_7, KEY_MIN,     1, 1'b0, 0, 4);
        add_row(KIND_DELETE, KEY_MIN,     1, 1'b1, 0, 3);
        add_row(KIND_SEARCH, KEY_MIN,     0, 1'b0, 0, 0);
        add_row(KIND_SEARCH, KEY_NEG_ONE, 0, 1'b0, 0, 0);
        add_row(KIND_DELETE, 32'sd12345,  1, 1'b0, 0, 3);
        add_row(KIND_INSERT, 32'sd7,      0, 1'b0, 0, 0);
        add_row(KIND_DELETE, KEY_MAX,     0, 1'b0, 0, 0);
        add_row(KIND_COUNT,  32'sd0,      1, 1'b1, 0, 3);
        add_row(KIND_CLEAR,  32'sd0,      1, 1'b1, 0, 0);
        add_row(KIND_SEARCH, KEY_NEG_ONE, 1, 1'b0, 0, 0);
        add_row(KIND_INSERT, 32'sd42,     1, 1'b1, 0, 1);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 31;
        rx_idle_pct = 69;
        foreach (dir_tab[i]) send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);
        wait_drained();

        run_phase(31, 69, PHASE_ITEMS);
        wait_drained();
        run_phase(69, 31, PHASE_ITEMS);
        wait_drained();

        // Hold the result side off while commands keep coming, so the block backs up.
        hold_left = HOLD_CYCLES;
        run_phase(0, 0, PHASE_ITEMS);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_cnt == 0 && result_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
